// ----- design/frc_pkg.sv -----
// Shared types, sizes and helpers for the frame ring buffer.
// Used by the top level, the checker and the byte store addressing.
package frc_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int MAX_FRAME   = 1514;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int OFF_W       = 11;
  localparam int SLOT_STRIDE = 2048;
  localparam int BYTE_AW     = SLOT_W + OFF_W;
  localparam int BYTE_DEPTH  = NUM_SLOTS * SLOT_STRIDE;
  localparam int HELD_W      = 4;
  localparam int CNT_W       = 32;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } frc_action_t;

  typedef struct packed {
    frc_action_t      action;
    logic [7:0]       push_byte;
    logic             push_last;
    logic [OFF_W-1:0] read_limit;
  } frc_req_t;

  typedef struct packed {
    logic [7:0]        pop_byte;
    logic              pop_valid;
    logic              pop_last;
    logic              ring_empty;
    logic              frame_dropping;
    logic [CNT_W-1:0]  accepted_frames;
    logic [CNT_W-1:0]  dropped_frames;
    logic [HELD_W-1:0] frames_held;
  } frc_res_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [HELD_W-1:0] slots_used(input logic [SLOT_W-1:0] head,
                                                   input logic [SLOT_W-1:0] tail);
    logic [SLOT_W:0] diff;
    diff = (head >= tail) ? {1'b0, head} - {1'b0, tail}
                          : {1'b0, head} + (SLOT_W+1)'(NUM_SLOTS) - {1'b0, tail};
    slots_used = HELD_W'(diff);
  endfunction

endpackage

// ----- design/frc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the frame bytes of the ring.
module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/frame_ring_with_drop_count.sv -----
// Receive frame ring: frames are pushed a byte per request and popped a byte
// per request. A request is taken whenever start is high and busy is low;
// busy never rises, so one request may be issued in every clock cycle. Each
// request yields exactly one result, shown on out_res for a single cycle with
// out_strobe high. The request passes the input register, then the result
// register together with the state update and the registered read of the
// byte store. Results leave in request order and cannot be held
// off, so the receiver must take every strobe. A push into a full ring (one
// slot is always kept free) drops the whole frame and counts it; bytes past
// the maximum frame length are discarded. There is no clearing pass after
// reset. Depends on frc_pkg and frc_ram.
module frame_ring_with_drop_count
  import frc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  frc_req_t in_req,
  output logic     out_strobe,
  output frc_res_t out_res
);

  // Stage 0: request register.
  logic     in_v_r;
  frc_req_t in_r;

  // Ring state.
  logic [SLOT_W-1:0] head_r,     head_nxt;
  logic [SLOT_W-1:0] tail_r,     tail_nxt;
  logic [OFF_W-1:0]  wr_off_r,   wr_off_nxt;
  logic [OFF_W-1:0]  rd_off_r,   rd_off_nxt;
  logic [OFF_W-1:0]  rd_len_r,   rd_len_nxt;
  logic              drop_r,     drop_nxt;
  logic [CNT_W-1:0]  acc_cnt_r,  acc_cnt_nxt;
  logic [CNT_W-1:0]  drop_cnt_r, drop_cnt_nxt;

  // Committed frame lengths, one per slot; only read once written.
  logic [OFF_W-1:0]  len_r [NUM_SLOTS];
  logic              len_we;
  logic [OFF_W-1:0]  len_wdata;

  // Byte store access.
  logic               ram_we;
  logic [BYTE_AW-1:0] ram_waddr;
  logic               ram_re;
  logic [BYTE_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  // Stage 1: result register (the byte itself comes from the store).
  logic     res_v_r;
  frc_res_t res_r, res_nxt;

  // Pop helpers.
  logic [OFF_W-1:0] len_sel;
  logic [OFF_W-1:0] len_eff;
  logic [OFF_W-1:0] rd_off_inc;
  logic             pop_has_byte;

  assign busy = 1'b0;

  // Register the request before it touches the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      in_r <= in_req;
    end
  end

  // Read limit is sampled only at the first pop of a frame.
  assign len_sel      = len_r[tail_r];
  assign len_eff      = (rd_off_r == '0) ? ((len_sel < in_r.read_limit) ? len_sel
                                                                        : in_r.read_limit)
                                         : rd_len_r;
  assign pop_has_byte = (rd_off_r < len_eff);
  assign rd_off_inc   = pop_has_byte ? rd_off_r + 1'b1 : rd_off_r;

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    wr_off_nxt   = wr_off_r;
    rd_off_nxt   = rd_off_r;
    rd_len_nxt   = rd_len_r;
    drop_nxt     = drop_r;
    acc_cnt_nxt  = acc_cnt_r;
    drop_cnt_nxt = drop_cnt_r;
    len_we       = 1'b0;
    len_wdata    = wr_off_r;
    ram_we       = 1'b0;
    ram_waddr    = {head_r, wr_off_r};
    ram_re       = 1'b0;
    ram_raddr    = {tail_r, rd_off_r};
    res_nxt      = '0;

    if (in_v_r) begin
      case (in_r.action)
        ACT_PUSH: begin
          if (!drop_r && wr_off_r == '0 && next_slot(head_r) == tail_r) begin
            // First byte into a full ring: drop the whole frame.
            drop_cnt_nxt           = drop_cnt_r + 1'b1;
            drop_nxt               = ~in_r.push_last;
            res_nxt.frame_dropping = 1'b1;
          end else if (drop_r) begin
            // Discard until the last byte of the dropped frame.
            res_nxt.frame_dropping = 1'b1;
            if (in_r.push_last) begin
              drop_nxt = 1'b0;
            end
          end else begin
            // Store the byte unless the frame has grown past the limit.
            if (wr_off_r < OFF_W'(MAX_FRAME)) begin
              ram_we     = 1'b1;
              wr_off_nxt = wr_off_r + 1'b1;
            end
            if (in_r.push_last) begin
              // Commit the length and advance the head.
              len_we      = 1'b1;
              len_wdata   = wr_off_nxt;
              head_nxt    = next_slot(head_r);
              acc_cnt_nxt = acc_cnt_r + 1'b1;
              wr_off_nxt  = '0;
            end
          end
        end
        ACT_POP: begin
          res_nxt.frame_dropping = drop_r;
          if (tail_r == head_r) begin
            res_nxt.ring_empty = 1'b1;
          end else begin
            rd_len_nxt        = len_eff;
            ram_re            = pop_has_byte;
            res_nxt.pop_valid = pop_has_byte;
            rd_off_nxt        = rd_off_inc;
            if (rd_off_inc >= len_eff) begin
              // Frame read out (or truncated): consume it.
              res_nxt.pop_last = 1'b1;
              rd_off_nxt       = '0;
              tail_nxt         = next_slot(tail_r);
            end
          end
        end
        default: begin
          res_nxt.frame_dropping = drop_r;
        end
      endcase
    end

    res_nxt.accepted_frames = acc_cnt_nxt;
    res_nxt.dropped_frames  = drop_cnt_nxt;
    res_nxt.frames_held     = slots_used(head_nxt, tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      wr_off_r   <= '0;
      rd_off_r   <= '0;
      rd_len_r   <= '0;
      drop_r     <= 1'b0;
      acc_cnt_r  <= '0;
      drop_cnt_r <= '0;
      res_v_r    <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      wr_off_r   <= wr_off_nxt;
      rd_off_r   <= rd_off_nxt;
      rd_len_r   <= rd_len_nxt;
      drop_r     <= drop_nxt;
      acc_cnt_r  <= acc_cnt_nxt;
      drop_cnt_r <= drop_cnt_nxt;
      res_v_r    <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_r[head_r] <= len_wdata;
    end
    res_r <= res_nxt;
  end

  // Frame bytes: slot in the upper address bits, offset in the lower.
  frc_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_DEPTH)
  ) u_bytes (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_r.push_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Drive the result; the byte reads as zero unless the pop carried one.
  always_comb begin
    out_res          = res_r;
    out_res.pop_byte = res_r.pop_valid ? ram_rdata : 8'd0;
  end

  assign out_strobe = res_v_r;

endmodule

// ----- design/frc_chk.sv -----
// Port-level checker for the frame ring, bound to the top level.
// Depends on frc_pkg; sees only the top level's ports.
module frc_chk
  import frc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input frc_res_t out_res
);

  // Every taken request gives a strobed result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("request gave no result");

  // No result without a request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##2 !out_strobe)
    else $error("result without a request");

  // An empty ring yields neither a byte nor a frame end.
  a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.ring_empty) |-> (!out_res.pop_valid && !out_res.pop_last))
    else $error("byte or frame end reported on an empty ring");

  // Between back-to-back results the accepted count moves by at most one.
  a_acc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(out_strobe) && $past(rst_n)) |->
      (out_res.accepted_frames == $past(out_res.accepted_frames) ||
       out_res.accepted_frames == $past(out_res.accepted_frames) + 32'd1))
    else $error("accepted count jumped");

endmodule

bind frame_ring_with_drop_count frc_chk u_frc_chk (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the frame ring with drop counting.
// Depends on frc_pkg and frame_ring_with_drop_count; needs nothing else.
module tb;
  import frc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 4;
  // Cycles with neither a request taken nor a result shown before giving up.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 200;
  // Final stretch of the random traffic that runs with no sender gaps.
  localparam int CALM_TAIL      = 60;
  // Extra wait at the end, after the awaited results have drained.
  localparam int TAIL_CYCLES    = 8;
  localparam logic [OFF_W-1:0] LIMIT_MAX = '1;

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     start      = 1'b0;
  logic     busy;
  frc_req_t in_req     = '0;
  logic     out_strobe;
  frc_res_t out_res;

  frame_ring_with_drop_count dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ring predictor: its own copy of the byte store, slot lengths, slot
  // pointers, offsets, discard flag and the two frame counters.
  // ---------------------------------------------------------------------------
  logic [7:0]        ring_bytes [BYTE_DEPTH];
  logic [OFF_W-1:0]  ring_len   [NUM_SLOTS];
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  logic [OFF_W-1:0]  wr_off, rd_off, rd_len;
  logic              discarding;
  logic [CNT_W-1:0]  n_stored, n_dropped;

  frc_res_t awaited_results [$];

  int n_errors   = 0;
  int n_sent     = 0;
  int n_taken    = 0;
  int n_checked  = 0;
  int idle_run   = 0;
  bit idle_on    = 1'b0;

  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    return SLOT_W'((int'(s) + 1) % NUM_SLOTS);
  endfunction

  task automatic clear_ring_model();
    wr_slot    = '0;
    rd_slot    = '0;
    wr_off     = '0;
    rd_off     = '0;
    rd_len     = '0;
    discarding = 1'b0;
    n_stored   = '0;
    n_dropped  = '0;
  endtask

  // Advance the predicted ring by one request and return the result it yields.
  function automatic frc_res_t ring_predict(input frc_req_t r);
    frc_res_t res;
    res = '0;
    if (r.action == ACT_PUSH) begin
      if (!discarding && wr_off == '0 && slot_after(wr_slot) == rd_slot) begin
        // First byte into a full ring: drop the whole frame and count it.
        n_dropped++;
        discarding         = !r.push_last;
        res.frame_dropping = 1'b1;
      end else if (discarding) begin
        res.frame_dropping = 1'b1;
        if (r.push_last)
          discarding = 1'b0;
      end else begin
        // Bytes past the maximum frame length fall away; the length saturates.
        if (int'(wr_off) < MAX_FRAME) begin
          ring_bytes[int'(wr_slot) * SLOT_STRIDE + int'(wr_off)] = r.push_byte;
          wr_off++;
        end
        if (r.push_last) begin
          ring_len[wr_slot] = wr_off;
          wr_slot           = slot_after(wr_slot);
          n_stored++;
          wr_off            = '0;
        end
      end
    end else begin
      res.frame_dropping = discarding;
      if (rd_slot == wr_slot) begin
        res.ring_empty = 1'b1;
      end else begin
        // The read limit counts only at the first pop of each frame.
        if (rd_off == '0)
          rd_len = (ring_len[rd_slot] < r.read_limit) ? ring_len[rd_slot] : r.read_limit;
        if (rd_off < rd_len) begin
          res.pop_byte  = ring_bytes[int'(rd_slot) * SLOT_STRIDE + int'(rd_off)];
          res.pop_valid = 1'b1;
          rd_off++;
        end
        // A zero limit lands here at once: the frame is consumed with no byte.
        if (rd_off >= rd_len) begin
          res.pop_last = 1'b1;
          rd_off       = '0;
          rd_slot      = slot_after(rd_slot);
        end
      end
    end
    res.accepted_frames = n_stored;
    res.dropped_frames  = n_dropped;
    res.frames_held     = HELD_W'((int'(wr_slot) + NUM_SLOTS - int'(rd_slot)) % NUM_SLOTS);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge, check each strobed result against the
  // oldest awaited one, and predict every request taken at this edge.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    frc_res_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $error("result strobed with no request waiting");
          n_errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("pop_byte",        32'(want.pop_byte),       32'(out_res.pop_byte));
          check_field("pop_valid",       32'(want.pop_valid),      32'(out_res.pop_valid));
          check_field("pop_last",        32'(want.pop_last),       32'(out_res.pop_last));
          check_field("ring_empty",      32'(want.ring_empty),     32'(out_res.ring_empty));
          check_field("frame_dropping",  32'(want.frame_dropping),
                      32'(out_res.frame_dropping));
          check_field("accepted_frames", want.accepted_frames,     out_res.accepted_frames);
          check_field("dropped_frames",  want.dropped_frames,      out_res.dropped_frames);
          check_field("frames_held",     32'(want.frames_held),    32'(out_res.frames_held));
          n_checked++;
        end
      end
      if (start && busy === 1'b0) begin
        awaited_results.push_back(ring_predict(in_req));
        n_taken++;
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_strobe === 1'b1)
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
  end

  initial begin
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request builders and the shared sender.
  // ---------------------------------------------------------------------------
  function automatic frc_req_t noise_req();
    frc_req_t r;
    r.action     = frc_action_t'($urandom_range(0, 1));
    r.push_byte  = 8'($urandom_range(0, 255));
    r.push_last  = 1'($urandom_range(0, 1));
    r.read_limit = OFF_W'($urandom_range(0, int'(LIMIT_MAX)));
    return r;
  endfunction

  function automatic frc_req_t push_req(input logic [7:0] b, input logic last);
    frc_req_t r;
    r           = noise_req();
    r.action    = ACT_PUSH;
    r.push_byte = b;
    r.push_last = last;
    return r;
  endfunction

  function automatic frc_req_t pop_req(input logic [OFF_W-1:0] limit);
    frc_req_t r;
    r            = noise_req();
    r.action     = ACT_POP;
    r.read_limit = limit;
    return r;
  endfunction

  // Mostly small reader sizes so that truncation happens often.
  function automatic logic [OFF_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIMIT_MAX;
      2, 3:    return OFF_W'($urandom_range(0, int'(LIMIT_MAX)));
      default: return OFF_W'($urandom_range(1, 10));
    endcase
  endfunction

  task automatic idle_burst(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start  <= 1'b0;
      in_req <= noise_req();
    end
  endtask

  // Present one request from a falling edge and hold it until it is taken.
  // Start stays high on return, so back-to-back requests leave no gap.
  task automatic send_request(input frc_req_t req);
    if (idle_on && $urandom_range(0, 7) == 0)
      idle_burst($urandom_range(1, 10));
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
    n_sent++;
  endtask

  // Hold the sender off until every awaited result has arrived.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_frame(input int len);
    for (int i = 0; i < len; i++)
      send_request(push_req(8'($urandom_range(0, 255)), i == len - 1));
  endtask

  task automatic pop_burst(input int count);
    repeat (count)
      send_request(pop_req(pick_limit()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Empty ring, extreme byte values, a zero read limit and a truncated read.
  task automatic test_empty_and_limits();
    send_request(pop_req(LIMIT_MAX));
    send_request(push_req(8'h00, 1'b1));
    send_request(push_req(8'hFF, 1'b0));
    send_request(push_req(8'h80, 1'b0));
    send_request(push_req(8'h01, 1'b1));
    // Zero limit: the one-byte frame goes at the first pop with no byte shown.
    send_request(pop_req('0));
    // Truncate the three-byte frame to two; the second limit must be ignored.
    send_request(pop_req(OFF_W'(2)));
    send_request(pop_req(LIMIT_MAX));
    send_request(pop_req(LIMIT_MAX));
    drain_results();
  endtask

  // A frame longer than the maximum: the excess bytes fall away on the way in,
  // and the frame is read back truncated to its first three bytes.
  task automatic test_overlong_frame();
    push_frame(MAX_FRAME + 2);
    send_request(pop_req(OFF_W'(3)));
    send_request(pop_req(LIMIT_MAX));
    send_request(pop_req(LIMIT_MAX));
    send_request(pop_req(LIMIT_MAX));
    drain_results();
  endtask

  // Fill the ring, drop a one-byte and a longer frame, pop while discarding.
  task automatic test_full_ring();
    repeat (NUM_SLOTS - 1)
      push_frame(1);
    send_request(push_req(8'($urandom_range(0, 255)), 1'b1));
    send_request(push_req(8'($urandom_range(0, 255)), 1'b0));
    // Room appears mid-frame, but the frame stays discarded to its last byte.
    send_request(pop_req(LIMIT_MAX));
    send_request(push_req(8'($urandom_range(0, 255)), 1'b0));
    send_request(push_req(8'($urandom_range(0, 255)), 1'b1));
    push_frame(2);
    drain_results();
  endtask

  // Phases that lean towards pushing or popping, so the ring swings between
  // full and empty; most traffic is whole frames and read bursts, the rest noise.
  task automatic test_random_traffic();
    int first, done, sent_prev, roll, push_pct, phase_left;
    bit drained;
    first      = n_sent;
    push_pct   = 50;
    phase_left = 0;
    drained    = 1'b0;
    done       = 0;
    while (done < RANDOM_ITEMS) begin
      if (phase_left <= 0) begin
        push_pct   = $urandom_range(25, 75);
        phase_left = $urandom_range(60, 200);
        idle_on    = ($urandom_range(0, 3) != 0);
      end
      if (done >= RANDOM_ITEMS - CALM_TAIL)
        idle_on = 1'b0;
      if (!drained && done >= RANDOM_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end
      sent_prev = n_sent;
      roll      = $urandom_range(0, 99);
      if (roll < 10)
        send_request(noise_req());
      else if (roll < 10 + push_pct * 9 / 10)
        push_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
      else
        pop_burst($urandom_range(1, 12));
      phase_left -= n_sent - sent_prev;
      done = n_sent - first;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, wait out the pipeline, report.
  // ---------------------------------------------------------------------------
  initial begin
    clear_ring_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    test_empty_and_limits();
    test_overlong_frame();
    test_full_ring();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d requests sent, %0d results checked", n_sent, n_checked);
    $display("summary: %0d frames stored, %0d dropped on a full ring", n_stored, n_dropped);
    if (n_errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- frame_ring_with_drop_count.f -----
design/frc_pkg.sv
design/frc_ram.sv
design/frame_ring_with_drop_count.sv
design/frc_chk.sv
tb/tb.sv
